// File: sv/d4w_pkg.sv
// ----------------------------------------------------------------------------
// d4w_pkg
// Shared types, widths and filter taps of the D4 forward wavelet level.
// ----------------------------------------------------------------------------
package d4w_pkg;

  localparam int MAX_BLOCK_DEF   = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int HW_W   = 6;
  localparam int POS_W  = 5;
  localparam int COEF_W = 17;
  localparam int TAP_W  = 16;

  localparam int HW_RESET  = 32;
  localparam int COEF_MAX  = 65535;
  localparam int COEF_MIN  = -65536;
  localparam int RND_BIAS  = 16384;
  localparam int FRAC_BITS = 15;

  // D4 taps in Q1.15
  localparam logic signed [TAP_W-1:0] TAP0 = 16'sd15826;
  localparam logic signed [TAP_W-1:0] TAP1 = 16'sd27411;
  localparam logic signed [TAP_W-1:0] TAP2 = 16'sd7345;
  localparam logic signed [TAP_W-1:0] TAP3 = -16'sd4240;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_PRIME,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic             valid;
    logic             prime;
    logic             detail;
    logic [POS_W-1:0] pos;
    logic             last;
  } issue_t;

  // tap k of the smooth or the detail filter
  function automatic logic signed [TAP_W-1:0] tap(input logic detail, input logic [1:0] k);
    logic signed [TAP_W-1:0] t;
    t = TAP0;
    case ({detail, k})
      3'b000:  t = TAP0;
      3'b001:  t = TAP1;
      3'b010:  t = TAP2;
      3'b011:  t = TAP3;
      3'b100:  t = TAP3;
      3'b101:  t = -TAP2;
      3'b110:  t = TAP1;
      3'b111:  t = -TAP0;
      default: t = TAP0;
    endcase
    return t;
  endfunction

endpackage

// File: sv/d4_wavelet_forward_level_top.sv
// ----------------------------------------------------------------------------
// d4_wavelet_forward_level_top
// One level of the Daubechies D4 forward wavelet transform over sample blocks.
// ----------------------------------------------------------------------------
// Samples of a block of 2*half_width are written one per cycle into two
// sample banks (even and odd indices). After the final sample the block is
// read back one sample pair per cycle while downstream does not stall: one
// priming read, then 2*half_width reads, each giving one coefficient, smooth
// ones first, then detail, with last on the final detail. Loading and compute
// do not overlap, and compute is limited by the single pair read per cycle
// from the banks. Input is stalled during compute. A coefficient passes the
// bank read, product, sum and output registers after its read; downstream
// stall freezes the filter pipeline. half_width resets to 32, a 0 acts as 1,
// values above MAX_BLOCK/2 act as MAX_BLOCK/2, and a write discards any partial block.
// ----------------------------------------------------------------------------
module d4_wavelet_forward_level_top #(
  parameter int MAX_BLOCK   = d4w_pkg::MAX_BLOCK_DEF,
  parameter int SAMPLE_BITS = d4w_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [d4w_pkg::HW_W-1:0]            cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_BITS-1:0]       sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [d4w_pkg::COEF_W-1:0]   coefficient,
  output logic                                is_detail,
  output logic [d4w_pkg::POS_W-1:0]           position,
  output logic                                last
);

  localparam int BANK_DEPTH = MAX_BLOCK / 2;
  localparam int PAIR_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  logic                          adv;
  logic                          wr_en_even, wr_en_odd;
  logic [PAIR_AW-1:0]            wr_addr;
  logic                          rd_en;
  logic [PAIR_AW-1:0]            rd_addr;
  d4w_pkg::issue_t               issue;
  logic signed [SAMPLE_BITS-1:0] rd_even, rd_odd;

  d4w_ctrl #(
    .MAX_BLOCK (MAX_BLOCK),
    .PAIR_AW   (PAIR_AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .adv        (adv),
    .wr_en_even (wr_en_even),
    .wr_en_odd  (wr_en_odd),
    .wr_addr    (wr_addr),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .issue      (issue)
  );

  d4w_bank #(
    .DEPTH (BANK_DEPTH),
    .AW    (PAIR_AW),
    .DW    (SAMPLE_BITS)
  ) u_bank_even (
    .clk   (clk),
    .we    (wr_en_even),
    .waddr (wr_addr),
    .wdata (sample),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_even)
  );

  d4w_bank #(
    .DEPTH (BANK_DEPTH),
    .AW    (PAIR_AW),
    .DW    (SAMPLE_BITS)
  ) u_bank_odd (
    .clk   (clk),
    .we    (wr_en_odd),
    .waddr (wr_addr),
    .wdata (sample),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_odd)
  );

  d4w_mac #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk         (clk),
    .rst         (rst),
    .issue       (issue),
    .rd_even     (rd_even),
    .rd_odd      (rd_odd),
    .adv         (adv),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .coefficient (coefficient),
    .is_detail   (is_detail),
    .position    (position),
    .last        (last)
  );

endmodule

// File: sv/d4w_bank.sv
// ----------------------------------------------------------------------------
// d4w_bank
// Sample bank: one write port, one registered read port.
// ----------------------------------------------------------------------------
module d4w_bank #(
  parameter int DEPTH = d4w_pkg::MAX_BLOCK_DEF / 2,
  parameter int AW    = 5,
  parameter int DW    = d4w_pkg::SAMPLE_BITS_DEF
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/d4w_ctrl.sv
// ----------------------------------------------------------------------------
// d4w_ctrl
// Block fill counter, half_width register and read sequencer.
// ----------------------------------------------------------------------------
module d4w_ctrl #(
  parameter int MAX_BLOCK = d4w_pkg::MAX_BLOCK_DEF,
  parameter int PAIR_AW   = 5
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [d4w_pkg::HW_W-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      adv,
  output logic                      wr_en_even,
  output logic                      wr_en_odd,
  output logic [PAIR_AW-1:0]        wr_addr,
  output logic                      rd_en,
  output logic [PAIR_AW-1:0]        rd_addr,
  output d4w_pkg::issue_t           issue
);

  localparam logic [d4w_pkg::HW_W-1:0] HALF_MAX = d4w_pkg::HW_W'(MAX_BLOCK / 2);
  localparam logic [d4w_pkg::HW_W-1:0] HW_ONE   = d4w_pkg::HW_W'(1);

  d4w_pkg::state_t                state, state_next;
  logic [d4w_pkg::HW_W-1:0]       half_width;
  logic [PAIR_AW-1:0]             fill_pair;
  logic                           fill_odd;
  logic [d4w_pkg::POS_W-1:0]      idx;
  logic                           pass;

  logic [d4w_pkg::HW_W-1:0]       hw_eff;
  logic                           accept;
  logic                           fill_done;
  logic                           step_last;
  logic [d4w_pkg::POS_W-1:0]      idx_inc;

  always_comb begin
    if (half_width == '0) begin
      hw_eff = HW_ONE;
    end else if (half_width > HALF_MAX) begin
      hw_eff = HALF_MAX;
    end else begin
      hw_eff = half_width;
    end
  end

  assign accept    = in_valid && (state == d4w_pkg::ST_FILL);
  assign fill_done = accept && fill_odd &&
                     (d4w_pkg::HW_W'(fill_pair) + HW_ONE == hw_eff);
  assign idx_inc   = idx + d4w_pkg::POS_W'(1);
  assign step_last = (d4w_pkg::HW_W'(idx) + HW_ONE == hw_eff);

  always_comb begin
    state_next = state;
    case (state)
      d4w_pkg::ST_FILL: begin
        if (fill_done) begin
          state_next = d4w_pkg::ST_PRIME;
        end
      end
      d4w_pkg::ST_PRIME: begin
        if (adv) begin
          state_next = d4w_pkg::ST_RUN;
        end
      end
      d4w_pkg::ST_RUN: begin
        if (adv && step_last && pass) begin
          state_next = d4w_pkg::ST_FILL;
        end
      end
      default: state_next = d4w_pkg::ST_FILL;
    endcase
  end

  always_comb begin
    in_stall     = (state != d4w_pkg::ST_FILL);
    wr_en_even   = accept && !fill_odd;
    wr_en_odd    = accept && fill_odd;
    wr_addr      = fill_pair;
    rd_en        = 1'b0;
    rd_addr      = '0;
    issue        = '0;
    issue.pos    = idx;
    issue.detail = pass;
    case (state)
      d4w_pkg::ST_PRIME: begin
        rd_en       = adv;
        issue.valid = adv;
        issue.prime = 1'b1;
      end
      d4w_pkg::ST_RUN: begin
        rd_en       = adv;
        rd_addr     = step_last ? '0 : idx_inc[PAIR_AW-1:0];
        issue.valid = adv;
        issue.last  = pass && step_last;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= d4w_pkg::ST_FILL;
      half_width <= d4w_pkg::HW_W'(d4w_pkg::HW_RESET);
      fill_pair  <= '0;
      fill_odd   <= 1'b0;
      idx        <= '0;
      pass       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        half_width <= cfg_data;
        fill_pair  <= '0;
        fill_odd   <= 1'b0;
      end else if (accept) begin
        fill_odd <= !fill_odd;
        if (fill_odd) begin
          fill_pair <= fill_done ? '0 : fill_pair + PAIR_AW'(1);
        end
      end
      if (state == d4w_pkg::ST_RUN && adv) begin
        if (step_last) begin
          idx  <= '0;
          pass <= !pass;
        end else begin
          idx <= idx_inc;
        end
      end
    end
  end

endmodule

// File: sv/d4w_mac.sv
// ----------------------------------------------------------------------------
// d4w_mac
// Four-tap filter pipeline: products, sum, round and clamp, output register.
// ----------------------------------------------------------------------------
module d4w_mac #(
  parameter int SAMPLE_BITS = d4w_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  d4w_pkg::issue_t                         issue,
  input  logic signed [SAMPLE_BITS-1:0]           rd_even,
  input  logic signed [SAMPLE_BITS-1:0]           rd_odd,
  output logic                                    adv,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [d4w_pkg::COEF_W-1:0]       coefficient,
  output logic                                    is_detail,
  output logic [d4w_pkg::POS_W-1:0]               position,
  output logic                                    last
);

  localparam int PROD_W = SAMPLE_BITS + d4w_pkg::TAP_W;
  localparam int ACC_W  = SAMPLE_BITS + d4w_pkg::TAP_W + 2;
  localparam int Q_W    = ACC_W - d4w_pkg::FRAC_BITS;
  localparam int SAT_W  = (Q_W > d4w_pkg::COEF_W) ? Q_W : d4w_pkg::COEF_W;
  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(d4w_pkg::COEF_MAX);
  localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(d4w_pkg::COEF_MIN);
  localparam logic signed [ACC_W-1:0] RND    = ACC_W'(d4w_pkg::RND_BIAS);

  d4w_pkg::issue_t               s1, s2, s3;
  logic signed [SAMPLE_BITS-1:0] prev_even, prev_odd;
  logic signed [SAMPLE_BITS-1:0] win [4];
  logic signed [PROD_W-1:0]      prod [4];
  logic signed [ACC_W-1:0]       sum;
  logic signed [ACC_W-1:0]       rounded;
  logic signed [Q_W-1:0]         q;
  logic signed [SAT_W-1:0]       q_ext;
  logic signed [d4w_pkg::COEF_W-1:0] coef_sat;

  assign adv = !out_valid || !out_stall;

  assign win[0] = prev_even;
  assign win[1] = prev_odd;
  assign win[2] = rd_even;
  assign win[3] = rd_odd;

  assign rounded = sum + RND;
  assign q       = $signed(rounded[ACC_W-1:d4w_pkg::FRAC_BITS]);
  assign q_ext   = SAT_W'(q);

  always_comb begin
    if (q_ext > SAT_HI) begin
      coef_sat = d4w_pkg::COEF_W'(d4w_pkg::COEF_MAX);
    end else if (q_ext < SAT_LO) begin
      coef_sat = d4w_pkg::COEF_W'(d4w_pkg::COEF_MIN);
    end else begin
      coef_sat = q_ext[d4w_pkg::COEF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid  <= 1'b0;
      s2.valid  <= 1'b0;
      s3.valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1        <= issue;
      s2        <= '{valid:  s1.valid && !s1.prime,
                     prime:  s1.prime,
                     detail: s1.detail,
                     pos:    s1.pos,
                     last:   s1.last};
      s3        <= s2;
      out_valid <= s3.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (s1.valid) begin
        prev_even <= rd_even;
        prev_odd  <= rd_odd;
        for (int k = 0; k < 4; k++) begin
          prod[k] <= PROD_W'(win[k]) * PROD_W'(d4w_pkg::tap(s1.detail, 2'(k)));
        end
      end
      sum <= ACC_W'(prod[0]) + ACC_W'(prod[1]) + ACC_W'(prod[2]) + ACC_W'(prod[3]);
      coefficient <= coef_sat;
      is_detail   <= s3.detail;
      position    <= s3.pos;
      last        <= s3.last;
    end
  end

endmodule
